// ----- rtl/deq_pkg.sv -----
package deq_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 5;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_DUMP       = 3'd5
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_POP_WAIT,
        S_SCAN
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    push_front;
        logic    push_back;
        logic    pop_front;
        logic    pop_back;
        logic    rd_front;
        logic    rd_back;
        logic    scan_init;
        logic    scan_run;
        logic    emit;
        status_t emit_status;
        logic    emit_data;
        logic    emit_pos;
        logic    emit_last;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [2:0] op;
        logic       empty;
        logic       full;
        logic       pend_valid;
        logic       match;
        logic       cmp_last;
    } stat_t;

endpackage

// ----- rtl/deque_with_search.sv -----
// Bounded double-ended queue of signed 32-bit values with search and dump.
// A request is taken at a rising edge where start is high and busy is low;
// operation and item_value are sampled at that edge. Every request except
// the unused operation codes ends in a result whose last_of_run is set.
// Each result appears on status, data_out, position and last_of_run for one
// cycle while strobe is high; the receiver must take it in that cycle.
// Pushes and any full or empty answer are decided in the decode state; a pop
// first reads the entry memory and is answered from the pop-wait state. Search
// and dump read the entry memory one entry per cycle through its registered
// port: dump results follow one another on consecutive cycles, and a search
// ends at the first matching position or, on a miss, after the last entry.
// busy falls in the cycle the final result is strobed, so the next request
// can be taken at the edge that ends that cycle.
// Reset empties the queue (front index and entry count cleared); memory
// contents are not cleared since only entries written by pushes are read.
module deque_with_search
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [2:0]               operation,
    input  logic signed [DATA_W-1:0] item_value,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [POS_W-1:0]         position,
    output logic                     last_of_run
);

    cmd_t  cmd;
    stat_t stat;

    deq_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .busy (busy),
        .stat (stat),
        .cmd  (cmd)
    );

    deq_dp #(
        .DEPTH(DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .operation  (operation),
        .item_value (item_value),
        .cmd        (cmd),
        .stat       (stat),
        .strobe     (strobe),
        .status     (status),
        .data_out   (data_out),
        .position   (position),
        .last_of_run(last_of_run)
    );

endmodule

// ----- rtl/deq_ram.sv -----
module deq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/deq_ctrl.sv -----
module deq_ctrl
    import deq_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    output logic  busy,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != S_IDLE);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                state_next = S_IDLE;
                case (stat.op) inside
                    OP_PUSH_FRONT, OP_PUSH_BACK:
                    begin
                        cmd.emit      = 1'b1;
                        cmd.emit_last = 1'b1;
                        if (stat.full)
                        begin
                            cmd.emit_status = ST_FULL;
                        end
                        else
                        begin
                            cmd.emit_status = ST_OK;
                            cmd.push_front  = (stat.op == OP_PUSH_FRONT);
                            cmd.push_back   = (stat.op == OP_PUSH_BACK);
                        end
                    end

                    OP_POP_FRONT, OP_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.rd_front = (stat.op == OP_POP_FRONT);
                            cmd.rd_back  = (stat.op == OP_POP_BACK);
                            state_next   = S_POP_WAIT;
                        end
                    end

                    OP_SEARCH, OP_DUMP:
                    begin
                        if (stat.empty)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.scan_init = 1'b1;
                            state_next    = S_SCAN;
                        end
                    end

                    default:
                    begin
                        // Unused operation codes produce no result.
                        state_next = S_IDLE;
                    end
                endcase
            end

            S_POP_WAIT:
            begin
                cmd.emit        = 1'b1;
                cmd.emit_last   = 1'b1;
                cmd.emit_status = ST_OK;
                cmd.emit_data   = 1'b1;
                cmd.pop_front   = (stat.op == OP_POP_FRONT);
                cmd.pop_back    = (stat.op == OP_POP_BACK);
                state_next      = S_IDLE;
            end

            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.pend_valid)
                begin
                    if (stat.op == OP_SEARCH)
                    begin
                        if (stat.match)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_OK;
                            cmd.emit_pos    = 1'b1;
                            state_next      = S_IDLE;
                        end
                        else if (stat.cmp_last)
                        begin
                            cmd.emit        = 1'b1;
                            cmd.emit_last   = 1'b1;
                            cmd.emit_status = ST_NOT_FOUND;
                            state_next      = S_IDLE;
                        end
                    end
                    else
                    begin
                        cmd.emit        = 1'b1;
                        cmd.emit_status = ST_OK;
                        cmd.emit_data   = 1'b1;
                        cmd.emit_last   = stat.cmp_last;
                        if (stat.cmp_last)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/deq_dp.sv -----
module deq_dp
    import deq_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [2:0]               operation,
    input  logic signed [DATA_W-1:0] item_value,
    input  cmd_t                     cmd,
    output stat_t                    stat,
    output logic                     strobe,
    output logic [1:0]               status,
    output logic signed [DATA_W-1:0] data_out,
    output logic [POS_W-1:0]         position,
    output logic                     last_of_run
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int PW = (CW > POS_W) ? CW : POS_W;

    logic [AW-1:0]     front_reg;
    logic [AW-1:0]     front_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [2:0]        op_reg;
    logic [DATA_W-1:0] val_reg;

    logic [CW-1:0]     rd_off_reg;
    logic [CW-1:0]     rd_off_next;
    logic [AW-1:0]     rd_addr_reg;
    logic [AW-1:0]     rd_addr_next;
    logic [CW-1:0]     cmp_off_reg;
    logic [CW-1:0]     cmp_off_next;
    logic              pend_valid_reg;
    logic              pend_valid_next;

    logic              strobe_reg;
    logic [1:0]        status_reg;
    logic [DATA_W-1:0] data_reg;
    logic [POS_W-1:0]  pos_reg;
    logic              last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [AW-1:0]     front_inc;
    logic [AW-1:0]     front_dec;
    logic [AW-1:0]     rd_addr_inc;
    logic [AW-1:0]     tail_idx;
    logic [AW-1:0]     back_idx;
    logic [SW-1:0]     tail_sum;
    logic [SW-1:0]     back_sum;
    logic [PW-1:0]     pos_ext;
    logic              scan_issue;

    function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] a);
        ring_inc = (a == AW'(DEPTH - 1)) ? '0 : a + AW'(1);
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] a);
        ring_dec = (a == '0) ? AW'(DEPTH - 1) : a - AW'(1);
    endfunction

    // Both sums stay below twice the depth, so one conditional subtract wraps them.
    always_comb
    begin
        front_inc   = ring_inc(front_reg);
        front_dec   = ring_dec(front_reg);
        rd_addr_inc = ring_inc(rd_addr_reg);
        tail_sum    = SW'(front_reg) + SW'(count_reg);
        back_sum    = tail_sum - SW'(1);
        tail_idx    = (tail_sum >= SW'(DEPTH)) ? AW'(tail_sum - SW'(DEPTH)) : AW'(tail_sum);
        back_idx    = (back_sum >= SW'(DEPTH)) ? AW'(back_sum - SW'(DEPTH)) : AW'(back_sum);
        pos_ext     = PW'(cmp_off_reg) + PW'(1);
        scan_issue  = cmd.scan_run && (rd_off_reg < count_reg);
    end

    always_comb
    begin
        front_next      = front_reg;
        count_next      = count_reg;
        rd_off_next     = rd_off_reg;
        rd_addr_next    = rd_addr_reg;
        cmp_off_next    = cmp_off_reg;
        pend_valid_next = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = tail_idx;
        ram_raddr       = rd_addr_reg;

        if (cmd.push_front)
        begin
            ram_we     = 1'b1;
            ram_waddr  = front_dec;
            front_next = front_dec;
            count_next = count_reg + CW'(1);
        end
        if (cmd.push_back)
        begin
            ram_we     = 1'b1;
            ram_waddr  = tail_idx;
            count_next = count_reg + CW'(1);
        end
        if (cmd.pop_front)
        begin
            front_next = front_inc;
            count_next = count_reg - CW'(1);
        end
        if (cmd.pop_back)
        begin
            count_next = count_reg - CW'(1);
        end

        if (cmd.rd_front)
        begin
            ram_raddr = front_reg;
        end
        if (cmd.rd_back)
        begin
            ram_raddr = back_idx;
        end

        // The walk keeps one read in flight; read data comes back in the cycle after its offset is issued.
        if (cmd.scan_init)
        begin
            ram_raddr       = front_reg;
            rd_off_next     = CW'(1);
            rd_addr_next    = front_inc;
            cmp_off_next    = '0;
            pend_valid_next = 1'b1;
        end
        if (scan_issue)
        begin
            ram_raddr       = rd_addr_reg;
            rd_off_next     = rd_off_reg + CW'(1);
            rd_addr_next    = rd_addr_inc;
            cmp_off_next    = rd_off_reg;
            pend_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg      <= '0;
            count_reg      <= '0;
            rd_off_reg     <= '0;
            rd_addr_reg    <= '0;
            cmp_off_reg    <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            front_reg      <= front_next;
            count_reg      <= count_next;
            rd_off_reg     <= rd_off_next;
            rd_addr_reg    <= rd_addr_next;
            cmp_off_reg    <= cmp_off_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= operation;
            val_reg <= item_value;
        end
        if (cmd.emit)
        begin
            status_reg <= cmd.emit_status;
            data_reg   <= cmd.emit_data ? ram_rdata : '0;
            pos_reg    <= cmd.emit_pos ? pos_ext[POS_W-1:0] : '0;
            last_reg   <= cmd.emit_last;
        end
    end

    deq_ram #(
        .WIDTH(DATA_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(val_reg),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_comb
    begin
        stat.op         = op_reg;
        stat.empty      = (count_reg == '0);
        stat.full       = (count_reg == CW'(DEPTH));
        stat.pend_valid = pend_valid_reg;
        stat.match      = (ram_rdata == val_reg);
        stat.cmp_last   = (cmp_off_reg == count_reg - CW'(1));
    end

    assign strobe      = strobe_reg;
    assign status      = status_reg;
    assign data_out    = data_reg;
    assign position    = pos_reg;
    assign last_of_run = last_reg;

endmodule

// ----- test/deque_with_search_tb.sv -----
`timescale 1ns / 1ps

import deq_pkg::*;

// Keeps a shadow copy of the ring buffer and the expected results in order.
class deque_scoreboard;
    localparam int SLOTS = 16;

    typedef struct {
        status_t            status;
        logic signed [31:0] data;
        logic [4:0]         pos;
        logic               last;
    } result_t;

    logic signed [31:0] ring [SLOTS];
    int                 head;
    int                 fill;
    result_t            expected_q [$];
    int                 errors;
    int                 requests;
    int                 ignored;
    int                 results;
    int                 full_hits;
    int                 empty_hits;
    int                 miss_hits;
    int                 peak_fill;

    function new();
        head       = 0;
        fill       = 0;
        errors     = 0;
        requests   = 0;
        ignored    = 0;
        results    = 0;
        full_hits  = 0;
        empty_hits = 0;
        miss_hits  = 0;
        peak_fill  = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void add_expected(status_t st, logic signed [31:0] data, logic [4:0] pos,
                               logic last);
        result_t r;
        r.status = st;
        r.data   = data;
        r.pos    = pos;
        r.last   = last;
        expected_q.push_back(r);
        if (st == ST_FULL)
            full_hits++;
        if (st == ST_EMPTY)
            empty_hits++;
        if (st == ST_NOT_FOUND)
            miss_hits++;
    endfunction

    // A value currently stored (a random one when empty), so that searches mostly find something.
    function logic signed [31:0] live_value();
        if (fill == 0)
            return $urandom;
        return ring[(head + $urandom_range(0, fill - 1)) % SLOTS];
    endfunction

    function void note_request(logic [2:0] op, logic signed [31:0] value);
        int  i;
        bit  found;
        requests++;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (fill == SLOTS)
                    add_expected(ST_FULL, 0, 0, 1'b1);
                else
                begin
                    if (op == OP_PUSH_FRONT)
                    begin
                        head = (head + SLOTS - 1) % SLOTS;
                        ring[head] = value;
                    end
                    else
                        ring[(head + fill) % SLOTS] = value;
                    fill++;
                    if (fill > peak_fill)
                        peak_fill = fill;
                    add_expected(ST_OK, 0, 0, 1'b1);
                end
            end
            OP_POP_FRONT:
            begin
                if (fill == 0)
                    add_expected(ST_EMPTY, 0, 0, 1'b1);
                else
                begin
                    add_expected(ST_OK, ring[head], 0, 1'b1);
                    head = (head + 1) % SLOTS;
                    fill--;
                end
            end
            OP_POP_BACK:
            begin
                if (fill == 0)
                    add_expected(ST_EMPTY, 0, 0, 1'b1);
                else
                begin
                    add_expected(ST_OK, ring[(head + fill - 1) % SLOTS], 0, 1'b1);
                    fill--;
                end
            end
            OP_SEARCH:
            begin
                if (fill == 0)
                    add_expected(ST_EMPTY, 0, 0, 1'b1);
                else
                begin
                    found = 1'b0;
                    for (i = 0; i < fill && !found; i++)
                    begin
                        if (ring[(head + i) % SLOTS] == value)
                        begin
                            add_expected(ST_OK, 0, 5'(i + 1), 1'b1);
                            found = 1'b1;
                        end
                    end
                    if (!found)
                        add_expected(ST_NOT_FOUND, 0, 0, 1'b1);
                end
            end
            OP_DUMP:
            begin
                if (fill == 0)
                    add_expected(ST_EMPTY, 0, 0, 1'b1);
                else
                    for (i = 0; i < fill; i++)
                        add_expected(ST_OK, ring[(head + i) % SLOTS], 0, i == fill - 1);
            end
            default:
                ignored++;
        endcase
    endfunction

    function void check_result(logic [1:0] st, logic signed [31:0] data, logic [4:0] pos,
                               logic last);
        result_t e;
        results++;
        if (expected_q.size() == 0)
        begin
            $error("result with nothing outstanding: status %0d data %0d position %0d",
                   st, data, pos);
            errors++;
            return;
        end
        e = expected_q.pop_front();
        if (st !== e.status)
        begin
            $error("status mismatch: expected %0d, got %0d", e.status, st);
            errors++;
        end
        if (data !== e.data)
        begin
            $error("data_out mismatch: expected %0d, got %0d", e.data, data);
            errors++;
        end
        if (pos !== e.pos)
        begin
            $error("position mismatch: expected %0d, got %0d", e.pos, pos);
            errors++;
        end
        if (last !== e.last)
        begin
            $error("last_of_run mismatch: expected %0d, got %0d", e.last, last);
            errors++;
        end
    endfunction
endclass

module deque_with_search_tb;

    localparam int RANDOM_ITEMS = 200;
    localparam int PHASE_ITEMS  = 24;
    localparam int IDLE_LIMIT   = 1000;
    localparam int TAIL_CYCLES  = 24;

    // Operation codes that the block ignores.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    typedef enum int {
        MIX_PHASE,
        FILL_PHASE,
        DRAIN_PHASE
    } phase_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic [2:0]               operation = '0;
    logic signed [DATA_W-1:0] item_value = '0;
    logic                     busy;
    logic                     strobe;
    logic [1:0]               status;
    logic signed [DATA_W-1:0] data_out;
    logic [POS_W-1:0]         position;
    logic                     last_of_run;

    deque_scoreboard sb = new();
    int              idle_cycles = 0;

    always #5 clk = ~clk;

    deque_with_search dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .operation   (operation),
        .item_value  (item_value),
        .strobe      (strobe),
        .status      (status),
        .data_out    (data_out),
        .position    (position),
        .last_of_run (last_of_run)
    );

    always @(posedge clk)
    begin
        if (rst_n && strobe === 1'b1)
            sb.check_result(status, data_out, position, last_of_run);
    end

    // Ends the run when neither a request nor a result has moved for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (start && busy === 1'b0) || strobe === 1'b1)
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_request(input logic [2:0] op, input logic signed [31:0] value);
        start      <= 1'b1;
        operation  <= op;
        item_value <= value;
        @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
        sb.note_request(op, value);
    endtask

    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start      <= 1'b0;
            operation  <= 3'($urandom);
            item_value <= $urandom;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic wait_all_results();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic signed [31:0] random_value();
        logic signed [31:0] v;
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0:       v = 32'sh8000_0000;
                    1:       v = 32'sh7FFF_FFFF;
                    2:       v = 32'sh0;
                    default: v = -32'sd1;
                endcase
            end
            // A small pool of values gives duplicates for the search to sort out.
            1, 2, 3: v = $signed($urandom_range(0, 6)) - 32'sd3;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic logic [2:0] pick_operation(phase_t phase);
        int r;
        int push_pct;
        int pop_pct;
        push_pct = (phase == FILL_PHASE) ? 75 : (phase == DRAIN_PHASE) ? 15 : 40;
        pop_pct  = (phase == DRAIN_PHASE) ? 60 : (phase == FILL_PHASE) ? 5 : 30;
        r = $urandom_range(0, 99);
        if (r < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        if (r < push_pct + pop_pct)
            return $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
        if (r < 96)
            return ($urandom_range(0, 9) < 7) ? OP_SEARCH : OP_DUMP;
        return $urandom_range(0, 1) ? OP_SPARE_A : OP_SPARE_B;
    endfunction

    initial
    begin
        int          done;
        int          in_phase;
        bit          no_gaps;
        bit          paused;
        phase_t      phase;
        logic [2:0]  op;
        logic signed [31:0] value;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Empty queue first, then the value extremes, duplicates and the unused codes.
        send_request(OP_POP_FRONT, 32'sh0);
        hold_off(pick_gap());
        send_request(OP_POP_BACK, -32'sd1);
        send_request(OP_SEARCH, 32'sh0);
        hold_off(pick_gap());
        send_request(OP_DUMP, 32'sh0);
        send_request(OP_PUSH_FRONT, 32'sh8000_0000);
        send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        hold_off(pick_gap());
        send_request(OP_PUSH_FRONT, 32'sh0);
        send_request(OP_PUSH_BACK, -32'sd1);
        send_request(OP_PUSH_BACK, 32'sh7FFF_FFFF);
        send_request(OP_SEARCH, 32'sh7FFF_FFFF);
        hold_off(pick_gap());
        send_request(OP_SEARCH, 32'sd12345);
        send_request(OP_SEARCH, -32'sd1);
        send_request(OP_DUMP, 32'sh0);
        hold_off(pick_gap());
        send_request(OP_POP_FRONT, 32'sh0);
        send_request(OP_POP_BACK, 32'sh0);
        send_request(OP_SPARE_A, 32'sh5A5A_5A5A);
        send_request(OP_SPARE_B, -32'sd1);
        send_request(OP_DUMP, 32'sh0);
        hold_off(pick_gap());

        done     = 0;
        in_phase = PHASE_ITEMS;
        no_gaps  = 1'b0;
        paused   = 1'b0;
        phase    = MIX_PHASE;
        while (done < RANDOM_ITEMS)
        begin
            if (in_phase == PHASE_ITEMS)
            begin
                in_phase = 0;
                phase    = phase_t'($urandom_range(0, 2));
                no_gaps  = ($urandom_range(0, 3) == 0);
            end
            op = pick_operation(phase);
            if (op == OP_SEARCH && $urandom_range(0, 9) < 7)
                value = sb.live_value();
            else
                value = random_value();
            send_request(op, value);
            if (op != OP_SPARE_A && op != OP_SPARE_B)
            begin
                done++;
                in_phase++;
            end
            if (!paused && done >= RANDOM_ITEMS / 2)
            begin
                paused = 1'b1;
                wait_all_results();
            end
            else if (!no_gaps)
                hold_off(pick_gap());
        end

        wait_all_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Ran %0d requests (%0d with unused codes), checked %0d results.",
                 sb.requests, sb.ignored, sb.results);
        $display("Saw %0d full, %0d empty and %0d not-found answers; peak occupancy %0d.",
                 sb.full_hits, sb.empty_hits, sb.miss_hits, sb.peak_fill);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/deq_pkg.sv
rtl/deq_ram.sv
rtl/deq_ctrl.sv
rtl/deq_dp.sv
rtl/deque_with_search.sv
test/deque_with_search_tb.sv
